// ===== rtl/core/affine_sprite_texel_mapper_top_macros.svh =====
// assertion macros shared by the texel mapper modules
// each macro expects clk and arst_n in the scope where it is used
`ifndef AFFINE_SPRITE_TEXEL_MAPPER_TOP_MACROS_SVH
`define AFFINE_SPRITE_TEXEL_MAPPER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASTM_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("astm: same-cycle check failed");

// next-cycle implication
`define ASTM_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("astm: next-cycle check failed");

`else

`define ASTM_ASSERT_IMP(name, ante, cons)
`define ASTM_ASSERT_NXT(name, ante, cons)

`endif

`endif

// ===== rtl/core/astm_pkg.sv =====
`timescale 1ns / 1ps

package astm_pkg;

	// payload field widths
	localparam int PIX_W     = 10;
	localparam int IDX_W     = 12;
	localparam int TEXEL_W   = 32;
	localparam int CFG_W     = 16;
	localparam int DIM_W     = 7;
	localparam int REG_IDX_W = 3;

	// defaults for the top-level parameters
	localparam int FB_WIDTH_DEF    = 1024;
	localparam int FB_HEIGHT_DEF   = 1024;
	localparam int MAX_TEXELS_DEF  = 4096;
	localparam int QUEUE_DEPTH_DEF = 4;

	// datapath widths
	localparam int DELTA_W       = 17;            // pixel*16 - origin
	localparam int PROD_W        = DELTA_W + CFG_W;   // delta * cos/sin
	localparam int ROT_W         = PROD_W + 1;    // rotated coordinate, Q.18
	localparam int SCALED_PROD_W = ROT_W + CFG_W + 1;
	localparam int SUM_W         = SCALED_PROD_W + 1;  // Q.26 texel coordinate
	localparam int QADDR_W       = 2 * DIM_W;     // row * width + column

	// bitmap centre is size/2 in Q.26, texel coordinate is the integer part
	localparam int CENTRE_SHIFT = 25;
	localparam int TEXEL_SHIFT  = 26;

	localparam logic [TEXEL_W-1:0] ALPHA_MASK = 32'h0000_00FF;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_COS_ANGLE     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SIN_ANGLE     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_RECIP_SCALE_X = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_RECIP_SCALE_Y = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_BITMAP_WIDTH  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_BITMAP_HEIGHT = 3'd7;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_MAP  = 1'b1
	} op_t;

	typedef struct packed {
		op_t                operation;
		logic [PIX_W-1:0]   pixel_x;
		logic [PIX_W-1:0]   pixel_y;
		logic [IDX_W-1:0]   texel_index;
		logic [TEXEL_W-1:0] texel_value;
	} item_t;

	typedef struct packed {
		logic [PIX_W-1:0]   out_x;
		logic [PIX_W-1:0]   out_y;
		logic [TEXEL_W-1:0] colour;
	} result_t;

	typedef struct packed {
		logic signed [CFG_W-1:0] cos_angle;
		logic signed [CFG_W-1:0] sin_angle;
		logic signed [CFG_W-1:0] origin_x;
		logic signed [CFG_W-1:0] origin_y;
		logic [CFG_W-1:0]        recip_scale_x;
		logic [CFG_W-1:0]        recip_scale_y;
		logic [DIM_W-1:0]        bitmap_width;
		logic [DIM_W-1:0]        bitmap_height;
	} cfg_t;

	// one command for the texel store side
	typedef struct packed {
		logic               is_load;
		logic [QADDR_W-1:0] addr;
		logic [PIX_W-1:0]   px;
		logic [PIX_W-1:0]   py;
		logic [TEXEL_W-1:0] value;
	} qent_t;

endpackage

// ===== rtl/core/astm_front.sv =====
`timescale 1ns / 1ps

module astm_front #(
	parameter int FB_WIDTH   = astm_pkg::FB_WIDTH_DEF,
	parameter int FB_HEIGHT  = astm_pkg::FB_HEIGHT_DEF,
	parameter int MAX_TEXELS = astm_pkg::MAX_TEXELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  astm_pkg::item_t     item,
	input  astm_pkg::cfg_t      cfg,
	output logic                push,
	output astm_pkg::qent_t     push_data,
	input  logic                full
);

	localparam int DW  = astm_pkg::DELTA_W;
	localparam int PW  = astm_pkg::PROD_W;
	localparam int RW  = astm_pkg::ROT_W;
	localparam int MW  = astm_pkg::SCALED_PROD_W;
	localparam int SW  = astm_pkg::SUM_W;
	localparam int QW  = astm_pkg::QADDR_W;
	localparam int TS  = astm_pkg::TEXEL_SHIFT;
	localparam int DMW = astm_pkg::DIM_W;

	logic en;

	logic v_s1, v_s2, v_s3, v_s4;
	astm_pkg::item_t itm_s1, itm_s2, itm_s3;
	logic infb_s1, infb_s2, infb_s3;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [RW-1:0] lx_s2, ly_s2;
	logic signed [SW-1:0] sx_s3, sy_s3;
	astm_pkg::qent_t ent_s4;
	logic keep_s4;

	logic signed [DW-1:0] dx_d, dy_d;
	logic infb_d;
	logic signed [PW-1:0] xc, ys, xs, yc;
	logic signed [RW-1:0] lx_d, ly_d;
	logic signed [MW-1:0] prod_x, prod_y;
	logic signed [SW-1:0] centre_x, centre_y, sx_d, sy_d;
	logic [DMW-1:0] tx_d, ty_d;
	logic tx_ok, ty_ok, addr_ok, idx_ok, keep_d;
	logic [QW-1:0] row_base, addr_d;
	astm_pkg::qent_t ent_d;

	// whole pipe stalls only when a kept command meets a full queue
	assign en         = !(v_s4 && keep_s4 && full);
	assign item_ready = en;
	assign push       = v_s4 && keep_s4 && !full;
	assign push_data  = ent_s4;

	// stage 1: offset from sprite centre, framebuffer bounds
	always_comb begin
		dx_d = $signed({3'b000, item.pixel_x, 4'b0000}) -
			$signed({cfg.origin_x[astm_pkg::CFG_W-1], cfg.origin_x});
		dy_d = $signed({3'b000, item.pixel_y, 4'b0000}) -
			$signed({cfg.origin_y[astm_pkg::CFG_W-1], cfg.origin_y});
		infb_d = (32'(item.pixel_x) < 32'(FB_WIDTH)) &&
			(32'(item.pixel_y) < 32'(FB_HEIGHT));
	end

	// stage 2: inverse rotation
	always_comb begin
		xc   = $signed(dx_s1) * $signed(cfg.cos_angle);
		ys   = $signed(dy_s1) * $signed(cfg.sin_angle);
		xs   = $signed(dx_s1) * $signed(cfg.sin_angle);
		yc   = $signed(dy_s1) * $signed(cfg.cos_angle);
		lx_d = RW'(xc) - RW'(ys);
		ly_d = RW'(xs) + RW'(yc);
	end

	// stage 3: reciprocal scale plus bitmap centre
	always_comb begin
		prod_x   = $signed(lx_s2) * $signed({1'b0, cfg.recip_scale_x});
		prod_y   = $signed(ly_s2) * $signed({1'b0, cfg.recip_scale_y});
		centre_x = $signed(SW'(cfg.bitmap_width) << astm_pkg::CENTRE_SHIFT);
		centre_y = $signed(SW'(cfg.bitmap_height) << astm_pkg::CENTRE_SHIFT);
		sx_d     = SW'(prod_x) + centre_x;
		sy_d     = SW'(prod_y) + centre_y;
	end

	// stage 4: floor, bitmap bounds, texel address
	always_comb begin
		tx_d  = sx_s3[TS+DMW-1:TS];
		ty_d  = sy_s3[TS+DMW-1:TS];
		tx_ok = !sx_s3[SW-1] && (sx_s3[SW-2:TS+DMW] == '0) && (tx_d < cfg.bitmap_width);
		ty_ok = !sy_s3[SW-1] && (sy_s3[SW-2:TS+DMW] == '0) && (ty_d < cfg.bitmap_height);
		row_base = QW'(ty_d) * QW'(cfg.bitmap_width);
		addr_d   = row_base + QW'(tx_d);
		addr_ok  = 32'(addr_d) < 32'(MAX_TEXELS);
		idx_ok   = 32'(itm_s3.texel_index) < 32'(MAX_TEXELS);

		ent_d.is_load = (itm_s3.operation == astm_pkg::OP_LOAD);
		ent_d.addr    = ent_d.is_load ? QW'(itm_s3.texel_index) : addr_d;
		ent_d.px      = itm_s3.pixel_x;
		ent_d.py      = itm_s3.pixel_y;
		ent_d.value   = itm_s3.texel_value;

		keep_d = ent_d.is_load ? idx_ok : (infb_s3 && tx_ok && ty_ok && addr_ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			itm_s1  <= item;
			infb_s1 <= infb_d;
			dx_s1   <= dx_d;
			dy_s1   <= dy_d;
			itm_s2  <= itm_s1;
			infb_s2 <= infb_s1;
			lx_s2   <= lx_d;
			ly_s2   <= ly_d;
			itm_s3  <= itm_s2;
			infb_s3 <= infb_s2;
			sx_s3   <= sx_d;
			sy_s3   <= sy_d;
			ent_s4  <= ent_d;
			keep_s4 <= keep_d;
		end
	end

endmodule

// ===== rtl/core/astm_queue.sv =====
`timescale 1ns / 1ps
`include "affine_sprite_texel_mapper_top_macros.svh"

module astm_queue #(
	parameter int DEPTH = astm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  astm_pkg::qent_t push_data,
	output logic            full,
	input  logic            pop,
	output astm_pkg::qent_t pop_data,
	output logic            empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	astm_pkg::qent_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	`ASTM_ASSERT_IMP(a_no_push_full, push, !full)
	`ASTM_ASSERT_IMP(a_no_pop_empty, pop, !empty)
	`ASTM_ASSERT_NXT(a_count_steady, (push && pop), $stable(count_q))

endmodule

// ===== rtl/core/astm_back.sv =====
`timescale 1ns / 1ps
`include "affine_sprite_texel_mapper_top_macros.svh"

module astm_back #(
	parameter int MAX_TEXELS = astm_pkg::MAX_TEXELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  astm_pkg::qent_t   head,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_ready,
	output astm_pkg::result_t result
);

	localparam int AW = $clog2(MAX_TEXELS);

	logic [astm_pkg::TEXEL_W-1:0] texel_store_q [MAX_TEXELS];

	logic b1_v_s1;
	logic [astm_pkg::PIX_W-1:0] px_s1, py_s1;
	logic [astm_pkg::TEXEL_W-1:0] rdata_s1;
	logic out_v_q;
	astm_pkg::result_t out_q;

	logic out_free, b1_free, wr_en, rd_en, opaque;
	logic [AW-1:0] mem_addr;

	assign out_free = !out_v_q || result_ready;
	assign b1_free  = !b1_v_s1 || out_free;
	// loads never wait on the output side
	assign pop      = !empty && (head.is_load || b1_free);
	assign wr_en    = pop && head.is_load;
	assign rd_en    = pop && !head.is_load;
	assign mem_addr = AW'(head.addr);
	assign opaque   = (rdata_s1 & astm_pkg::ALPHA_MASK) != '0;

	assign result_valid = out_v_q;
	assign result       = out_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			texel_store_q[mem_addr] <= head.value;
		end
		if (rd_en) begin
			rdata_s1 <= texel_store_q[mem_addr];
			px_s1    <= head.px;
			py_s1    <= head.py;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (b1_free) begin
				b1_v_s1 <= rd_en;
			end
			if (out_free) begin
				out_v_q <= b1_v_s1 && opaque;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && b1_v_s1) begin
			out_q.out_x  <= px_s1;
			out_q.out_y  <= py_s1;
			out_q.colour <= rdata_s1;
		end
	end

	`ASTM_ASSERT_IMP(a_out_opaque, out_v_q, ((out_q.colour & astm_pkg::ALPHA_MASK) != '0))
	`ASTM_ASSERT_NXT(a_b1_holds, (b1_v_s1 && !out_free), b1_v_s1)
	`ASTM_ASSERT_NXT(a_rdata_holds, (b1_v_s1 && !out_free), $stable(rdata_s1))

endmodule

// ===== rtl/core/affine_sprite_texel_mapper_top.sv =====
`timescale 1ns / 1ps
// Rotated and scaled sprite texel mapper. A load transaction (operation 0) writes one RGBA
// texel into a MAX_TEXELS-word texel store; a map transaction (operation 1) takes a
// framebuffer pixel, subtracts the sprite centre, rotates by the configured cos/sin (Q2.14),
// multiplies by the reciprocal scales (Q8.8), adds the bitmap centre and floors to a texel.
// If the pixel is in the framebuffer, the texel in the bitmap and texel store, with a nonzero
// low alpha byte, one result carries pixel coordinate and texel word; otherwise nothing
// comes out. Loads and maps are kept in order, so a map sees every earlier load. Sustained
// rate is one transaction per clock when nothing stalls, set by the single texel store port
// that each load or map uses once; a map passes the front stages, queue, read and output
// registers. The texel store is not cleared at reset: an unloaded texel gives an undefined
// colour. Configuration must be written only while the block is idle; nothing checks this.

module affine_sprite_texel_mapper_top #(
	parameter int FB_WIDTH    = astm_pkg::FB_WIDTH_DEF,
	parameter int FB_HEIGHT   = astm_pkg::FB_HEIGHT_DEF,
	parameter int MAX_TEXELS  = astm_pkg::MAX_TEXELS_DEF,
	parameter int QUEUE_DEPTH = astm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [astm_pkg::REG_IDX_W-1:0] cfg_idx,
	input  logic [astm_pkg::CFG_W-1:0]     cfg_wdata,
	// input transactions
	input  logic                           item_valid,
	output logic                           item_ready,
	input  astm_pkg::item_t                item,
	// result transactions
	output logic                           result_valid,
	input  logic                           result_ready,
	output astm_pkg::result_t              result
);

	astm_pkg::cfg_t  cfg_q;
	astm_pkg::qent_t push_data, pop_data;
	logic push, pop, full, empty;

	// configuration registers, reset to identity transform and a 64x64 bitmap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cos_angle     <= 16'sd16384;
			cfg_q.sin_angle     <= '0;
			cfg_q.origin_x      <= '0;
			cfg_q.origin_y      <= '0;
			cfg_q.recip_scale_x <= 16'd256;
			cfg_q.recip_scale_y <= 16'd256;
			cfg_q.bitmap_width  <= 7'd64;
			cfg_q.bitmap_height <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				astm_pkg::REG_COS_ANGLE:     cfg_q.cos_angle     <= $signed(cfg_wdata);
				astm_pkg::REG_SIN_ANGLE:     cfg_q.sin_angle     <= $signed(cfg_wdata);
				astm_pkg::REG_ORIGIN_X:      cfg_q.origin_x      <= $signed(cfg_wdata);
				astm_pkg::REG_ORIGIN_Y:      cfg_q.origin_y      <= $signed(cfg_wdata);
				astm_pkg::REG_RECIP_SCALE_X: cfg_q.recip_scale_x <= cfg_wdata;
				astm_pkg::REG_RECIP_SCALE_Y: cfg_q.recip_scale_y <= cfg_wdata;
				// bitmap sizes keep the low seven bits
				astm_pkg::REG_BITMAP_WIDTH:  cfg_q.bitmap_width  <= cfg_wdata[astm_pkg::DIM_W-1:0];
				astm_pkg::REG_BITMAP_HEIGHT: cfg_q.bitmap_height <= cfg_wdata[astm_pkg::DIM_W-1:0];
				default:                     cfg_q <= cfg_q;
			endcase
		end
	end

	// front: four-stage coordinate pipeline, drops misses and out-of-range loads
	astm_front #(
		.FB_WIDTH   (FB_WIDTH),
		.FB_HEIGHT  (FB_HEIGHT),
		.MAX_TEXELS (MAX_TEXELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cfg        (cfg_q),
		.push       (push),
		.push_data  (push_data),
		.full       (full)
	);

	// short command queue, decouples math from texel store and output stalls
	astm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// back: texel store write or registered read, alpha test, output register
	astm_back #(
		.MAX_TEXELS (MAX_TEXELS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head         (pop_data),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
